// ===== rtl/core/indexed_ordered_list_core_defines.svh =====
// Assertion macros shared by the list core.
`ifndef INDEXED_ORDERED_LIST_CORE_DEFINES_SVH
`define INDEXED_ORDERED_LIST_CORE_DEFINES_SVH

// Checked on every rising clock edge outside of reset.
`define IOL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising clock edge, reset included.
`define IOL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/core/iol_pkg.sv =====
package iol_pkg;

  localparam int unsigned DEFAULT_DEPTH = 16;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned POS_W         = 5;
  localparam int unsigned COUNT_W       = 5;
  // Wide enough to name any cell of the deepest supported list.
  localparam int unsigned AT_W          = 11;

  typedef enum logic [2:0] {
    OP_APPEND     = 3'd0,
    OP_PREPEND    = 3'd1,
    OP_DROP_BACK  = 3'd2,
    OP_DROP_FRONT = 3'd3,
    OP_INSERT     = 3'd4,
    OP_REMOVE     = 3'd5,
    OP_CLEAR      = 3'd6,
    OP_QUERY      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_IGNORED = 2'd1,
    ST_FULL    = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_OPEN  = 2'd1,
    CELL_CLOSE = 2'd2
  } cell_cmd_e;

  typedef struct packed {
    op_e                      op;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                  status;
    logic [COUNT_W-1:0]       count;
    logic                     has_items;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] back_value;
  } rsp_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    cell_cmd_e          cmd;
    logic [AT_W-1:0]    at;
    logic [DATA_W-1:0]  value;
  } cell_ctl_t;

endpackage

// ===== rtl/core/iol_cell.sv =====
module iol_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                           clk_i,
  input  iol_pkg::cell_ctl_t             ctl_i,
  input  logic [iol_pkg::DATA_W-1:0]     left_i,
  input  logic [iol_pkg::DATA_W-1:0]     right_i,
  output logic [iol_pkg::DATA_W-1:0]     value_o
);

  localparam logic [iol_pkg::AT_W-1:0] IDX = iol_pkg::AT_W'(INDEX);

  logic [iol_pkg::DATA_W-1:0] slot_q;
  logic [iol_pkg::DATA_W-1:0] slot_d;

  // Opening a gap moves everything at or after it one cell toward the back;
  // closing one pulls everything after it one cell toward the front.
  always_comb begin
    slot_d = slot_q;
    case (ctl_i.cmd)
      iol_pkg::CELL_OPEN: begin
        if (IDX > ctl_i.at) begin
          slot_d = left_i;
        end else if (IDX == ctl_i.at) begin
          slot_d = ctl_i.value;
        end
      end
      iol_pkg::CELL_CLOSE: begin
        if (IDX >= ctl_i.at) begin
          slot_d = right_i;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  assign value_o = slot_q;

endmodule

// ===== rtl/core/indexed_ordered_list_core.sv =====
// Channel  | Direction | Handshake                  | Payload
// ---------+-----------+----------------------------+-------------------
// request  | in        | in_valid_i / in_stall_o    | in_req_i (req_t)
// response | out       | out_valid_o / out_stall_i  | out_rsp_o (rsp_t)
//
// A request is handled in two steps: the cell chain shifts in the cycle it is taken,
// and the front and back values are then selected and registered once the output register is free.
// No new request is taken until the last one has loaded the output register; the input stalls in the cycle
// after every transfer, and longer while a response waits in the output register.
// Reset empties the list at once; cell contents are not cleared.
`include "indexed_ordered_list_core_defines.svh"

module indexed_ordered_list_core #(
  parameter int unsigned DEPTH = iol_pkg::DEFAULT_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  iol_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output iol_pkg::rsp_t out_rsp_o
);

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned CMP_W = (CNT_W > iol_pkg::POS_W) ? CNT_W : iol_pkg::POS_W;

  logic [CNT_W-1:0]         held_q, held_d;
  logic                     busy_q, busy_d;
  iol_pkg::status_e         status_q, status_d;
  logic                     out_valid_q, out_valid_d;
  iol_pkg::rsp_t            out_q, out_d;
  iol_pkg::cell_ctl_t       ctl;
  logic [iol_pkg::DATA_W-1:0] slot [DEPTH];
  logic [iol_pkg::DATA_W-1:0] back_sel;

  logic             in_xfer;
  logic             out_free;
  logic             full;
  logic             empty;
  logic [CMP_W-1:0] pos_c;
  logic [CMP_W-1:0] held_c;

  assign in_xfer    = in_valid_i && !busy_q;
  assign in_stall_o = busy_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign full       = (held_q == CNT_W'(DEPTH));
  assign empty      = (held_q == '0);
  assign pos_c      = CMP_W'(in_req_i.position);
  assign held_c     = CMP_W'(held_q);

  // Request decode: count update, status, and the command for the cells.
  always_comb begin
    held_d    = held_q;
    status_d  = status_q;
    busy_d    = busy_q;
    ctl.cmd   = iol_pkg::CELL_HOLD;
    ctl.at    = '0;
    ctl.value = in_req_i.value;
    if (in_xfer) begin
      busy_d   = 1'b1;
      status_d = iol_pkg::ST_DONE;
      case (in_req_i.op)
        iol_pkg::OP_APPEND: begin
          if (full) begin
            status_d = iol_pkg::ST_FULL;
          end else begin
            ctl.cmd = iol_pkg::CELL_OPEN;
            ctl.at  = iol_pkg::AT_W'(held_q);
            held_d  = held_q + CNT_W'(1);
          end
        end
        iol_pkg::OP_PREPEND: begin
          if (full) begin
            status_d = iol_pkg::ST_FULL;
          end else begin
            ctl.cmd = iol_pkg::CELL_OPEN;
            held_d  = held_q + CNT_W'(1);
          end
        end
        iol_pkg::OP_DROP_BACK: begin
          if (empty) begin
            status_d = iol_pkg::ST_IGNORED;
          end else begin
            held_d = held_q - CNT_W'(1);
          end
        end
        iol_pkg::OP_DROP_FRONT: begin
          if (empty) begin
            status_d = iol_pkg::ST_IGNORED;
          end else begin
            ctl.cmd = iol_pkg::CELL_CLOSE;
            held_d  = held_q - CNT_W'(1);
          end
        end
        iol_pkg::OP_INSERT: begin
          // A position past the end is reported before a full list.
          if (pos_c > held_c) begin
            status_d = iol_pkg::ST_IGNORED;
          end else if (full) begin
            status_d = iol_pkg::ST_FULL;
          end else begin
            ctl.cmd = iol_pkg::CELL_OPEN;
            ctl.at  = iol_pkg::AT_W'(in_req_i.position);
            held_d  = held_q + CNT_W'(1);
          end
        end
        iol_pkg::OP_REMOVE: begin
          if (pos_c >= held_c) begin
            status_d = iol_pkg::ST_IGNORED;
          end else begin
            ctl.cmd = iol_pkg::CELL_CLOSE;
            ctl.at  = iol_pkg::AT_W'(in_req_i.position);
            held_d  = held_q - CNT_W'(1);
          end
        end
        iol_pkg::OP_CLEAR: begin
          held_d = '0;
        end
        default: begin
        end
      endcase
    end else if (busy_q && out_free) begin
      busy_d = 1'b0;
    end
  end

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [iol_pkg::DATA_W-1:0] left;
    logic [iol_pkg::DATA_W-1:0] right;
    if (g == 0) begin : g_first
      assign left = slot[g];
    end else begin : g_mid_l
      assign left = slot[g-1];
    end
    if (g == DEPTH - 1) begin : g_last
      assign right = slot[g];
    end else begin : g_mid_r
      assign right = slot[g+1];
    end
    iol_cell #(
      .INDEX (g)
    ) u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .left_i  (left),
      .right_i (right),
      .value_o (slot[g])
    );
  end

  // At most one cell sits at the back, so an OR over the masked cells picks it.
  always_comb begin
    back_sel = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (held_q == CNT_W'(i + 1)) begin
        back_sel = back_sel | slot[i];
      end
    end
  end

  always_comb begin
    out_d       = out_q;
    out_valid_d = out_valid_q;
    if (busy_q && out_free) begin
      out_valid_d       = 1'b1;
      out_d.status      = status_q;
      out_d.count       = iol_pkg::COUNT_W'(held_q);
      out_d.has_items   = !empty;
      out_d.front_value = empty ? '0 : slot[0];
      out_d.back_value  = empty ? '0 : back_sel;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      busy_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      held_q      <= held_d;
      busy_q      <= busy_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  `IOL_ASSERT(a_held_bound, held_q <= CNT_W'(DEPTH), "element count above depth")
  `IOL_ASSERT(a_take_starts_work, in_xfer |=> busy_q, "taken request did not start")
  `IOL_ASSERT(a_finish_loads_out, busy_q && out_free |=> out_valid_q && !busy_q,
              "finished request did not reach the output register")
  `IOL_ASSERT(a_held_steady, !in_xfer |=> $stable(held_q), "count changed without a request")
  `IOL_ASSERT(a_empty_zero, out_valid_q && !out_q.has_items |->
              out_q.front_value == '0 && out_q.back_value == '0,
              "empty list reported nonzero end values")

endmodule

// ===== sim/indexed_ordered_list_core_tb.sv =====
module indexed_ordered_list_core_tb;

  localparam int unsigned DEPTH      = iol_pkg::DEFAULT_DEPTH;
  localparam int unsigned NUM_ITEMS  = 750;
  localparam int unsigned IDLE_LIMIT = 1000;

  // Tracks the list contents and the responses still owed by the core.
  class list_scoreboard;
    logic signed [iol_pkg::DATA_W-1:0] entries[$];
    iol_pkg::rsp_t                     awaited_rsps[$];
    int unsigned                       depth;
    int unsigned                       errors;

    function new(int unsigned list_depth);
      depth  = list_depth;
      errors = 0;
    endfunction

    function int unsigned pending();
      return awaited_rsps.size();
    endfunction

    // Applies one accepted request to the list and queues the response it must produce.
    function void note_request(iol_pkg::req_t req);
      iol_pkg::status_e st;
      iol_pkg::rsp_t    rsp;
      st = iol_pkg::ST_DONE;
      case (req.op)
        iol_pkg::OP_APPEND: begin
          if (entries.size() >= depth) st = iol_pkg::ST_FULL;
          else entries.insert(entries.size(), req.value);
        end
        iol_pkg::OP_PREPEND: begin
          if (entries.size() >= depth) st = iol_pkg::ST_FULL;
          else entries.insert(0, req.value);
        end
        iol_pkg::OP_DROP_BACK: begin
          if (entries.size() == 0) st = iol_pkg::ST_IGNORED;
          else entries.delete(entries.size() - 1);
        end
        iol_pkg::OP_DROP_FRONT: begin
          if (entries.size() == 0) st = iol_pkg::ST_IGNORED;
          else entries.delete(0);
        end
        iol_pkg::OP_INSERT: begin
          // A position past the end is rejected before fullness is considered.
          if (int'(req.position) > entries.size()) st = iol_pkg::ST_IGNORED;
          else if (entries.size() >= depth) st = iol_pkg::ST_FULL;
          else entries.insert(int'(req.position), req.value);
        end
        iol_pkg::OP_REMOVE: begin
          if (int'(req.position) >= entries.size()) st = iol_pkg::ST_IGNORED;
          else entries.delete(int'(req.position));
        end
        iol_pkg::OP_CLEAR: begin
          entries.delete();
        end
        default: begin
        end
      endcase
      rsp.status      = st;
      rsp.count       = iol_pkg::COUNT_W'(entries.size());
      rsp.has_items   = (entries.size() != 0);
      rsp.front_value = (entries.size() != 0) ? entries[0] : '0;
      rsp.back_value  = (entries.size() != 0) ? entries[$] : '0;
      awaited_rsps.insert(awaited_rsps.size(), rsp);
    endfunction

    function void compare(string field, logic [iol_pkg::DATA_W-1:0] want,
                          logic [iol_pkg::DATA_W-1:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_response(iol_pkg::rsp_t got);
      iol_pkg::rsp_t want;
      if (awaited_rsps.size() == 0) begin
        $error("response transfer with no request outstanding");
        errors++;
        return;
      end
      want = awaited_rsps[0];
      awaited_rsps.delete(0);
      compare("status", iol_pkg::DATA_W'(want.status), iol_pkg::DATA_W'(got.status));
      compare("count", iol_pkg::DATA_W'(want.count), iol_pkg::DATA_W'(got.count));
      compare("has_items", iol_pkg::DATA_W'(want.has_items),
              iol_pkg::DATA_W'(got.has_items));
      compare("front_value", want.front_value, got.front_value);
      compare("back_value", want.back_value, got.back_value);
    endfunction
  endclass

  logic          clk_i;
  logic          rst_ni;
  logic          in_valid_i;
  logic          in_stall_o;
  iol_pkg::req_t in_req_i;
  logic          out_valid_o;
  logic          out_stall_i;
  iol_pkg::rsp_t out_rsp_o;

  list_scoreboard sb;
  bit             calm;
  int unsigned    idle_cycles;

  indexed_ordered_list_core #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(99) < 16);
  end

  // Monitor and watchdog: both channels are sampled at the edge where a transfer completes.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_response(out_rsp_o);
      if (in_valid_i && !in_stall_o) sb.note_request(in_req_i);
      if ((out_valid_o && !out_stall_i) || (in_valid_i && !in_stall_o)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  task automatic send_request(input iol_pkg::op_e op, input logic [iol_pkg::POS_W-1:0] pos,
                              input logic signed [iol_pkg::DATA_W-1:0] val);
    iol_pkg::req_t req;
    req.op       = op;
    req.position = pos;
    req.value    = val;
    if (!calm && ($urandom_range(99) < 16)) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_req_i   <= req;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  // Holds off the request side until every outstanding response has been seen.
  task automatic wait_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  // Mode 0 mostly grows the list, mode 1 mostly shrinks it, mode 2 mixes evenly.
  function automatic iol_pkg::op_e pick_op(int unsigned mode);
    int unsigned r;
    r = $urandom_range(99);
    if (mode == 0) begin
      if (r < 30) return iol_pkg::OP_APPEND;
      if (r < 55) return iol_pkg::OP_PREPEND;
      if (r < 80) return iol_pkg::OP_INSERT;
      if (r < 85) return iol_pkg::OP_DROP_BACK;
      if (r < 88) return iol_pkg::OP_DROP_FRONT;
      if (r < 93) return iol_pkg::OP_REMOVE;
      if (r < 95) return iol_pkg::OP_CLEAR;
      return iol_pkg::OP_QUERY;
    end else if (mode == 1) begin
      if (r < 25) return iol_pkg::OP_DROP_BACK;
      if (r < 50) return iol_pkg::OP_DROP_FRONT;
      if (r < 75) return iol_pkg::OP_REMOVE;
      if (r < 82) return iol_pkg::OP_APPEND;
      if (r < 87) return iol_pkg::OP_PREPEND;
      if (r < 92) return iol_pkg::OP_INSERT;
      if (r < 94) return iol_pkg::OP_CLEAR;
      return iol_pkg::OP_QUERY;
    end
    if (r < 14) return iol_pkg::OP_APPEND;
    if (r < 28) return iol_pkg::OP_PREPEND;
    if (r < 40) return iol_pkg::OP_DROP_BACK;
    if (r < 52) return iol_pkg::OP_DROP_FRONT;
    if (r < 68) return iol_pkg::OP_INSERT;
    if (r < 84) return iol_pkg::OP_REMOVE;
    if (r < 87) return iol_pkg::OP_CLEAR;
    return iol_pkg::OP_QUERY;
  endfunction

  function automatic logic [iol_pkg::POS_W-1:0] pick_position();
    if ($urandom_range(99) < 8) return iol_pkg::POS_W'($urandom_range(17, 31));
    return iol_pkg::POS_W'($urandom_range(0, $urandom_range(0, DEPTH)));
  endfunction

  initial begin
    int unsigned mode;
    clk_i       = 1'b0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    out_stall_i = 1'b0;
    calm        = 1'b0;
    idle_cycles = 0;
    mode        = 2;
    sb          = new(DEPTH);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // A query, then requests that an empty list must ignore.
    send_request(iol_pkg::OP_QUERY, '0, '0);
    send_request(iol_pkg::OP_DROP_BACK, '0, '0);
    send_request(iol_pkg::OP_DROP_FRONT, '0, '0);
    send_request(iol_pkg::OP_REMOVE, '0, '0);
    send_request(iol_pkg::OP_INSERT, 5'd1, 32'sh7fffffff);

    send_request(iol_pkg::OP_INSERT, '0, 32'sh80000000);
    send_request(iol_pkg::OP_APPEND, '0, 32'sh7fffffff);
    send_request(iol_pkg::OP_PREPEND, '0, -32'sd1);
    send_request(iol_pkg::OP_INSERT, 5'd3, '0);
    send_request(iol_pkg::OP_REMOVE, 5'd31, '0);
    send_request(iol_pkg::OP_REMOVE, 5'd2, '0);
    send_request(iol_pkg::OP_DROP_FRONT, '0, '0);
    send_request(iol_pkg::OP_DROP_BACK, '0, '0);

    // Fill the list, then probe it while full.
    for (int i = 0; i < DEPTH - 2; i++) begin
      case (i % 3)
        0:       send_request(iol_pkg::OP_APPEND, '0, $urandom());
        1:       send_request(iol_pkg::OP_PREPEND, '0, $urandom());
        default: send_request(iol_pkg::OP_INSERT,
                              iol_pkg::POS_W'($urandom_range(0, i + 2)), $urandom());
      endcase
    end
    send_request(iol_pkg::OP_APPEND, '0, $urandom());
    send_request(iol_pkg::OP_PREPEND, '0, $urandom());
    send_request(iol_pkg::OP_INSERT, iol_pkg::POS_W'(DEPTH + 1), $urandom());
    send_request(iol_pkg::OP_INSERT, iol_pkg::POS_W'(DEPTH), $urandom());
    send_request(iol_pkg::OP_REMOVE, iol_pkg::POS_W'(DEPTH), '0);
    send_request(iol_pkg::OP_REMOVE, iol_pkg::POS_W'(DEPTH - 1), '0);
    send_request(iol_pkg::OP_QUERY, '0, '0);
    send_request(iol_pkg::OP_CLEAR, '0, '0);

    for (int n = 0; n < NUM_ITEMS; n++) begin
      if (n % 40 == 0) mode = $urandom_range(2);
      if (n == 300) wait_until_drained();
      calm = (n >= 420) && (n < 540);
      send_request(pick_op(mode), pick_position(), $urandom());
    end
    calm = 1'b0;

    wait_until_drained();
    repeat (8) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
